// ===== hw/rtl/shq_pkg.sv =====
package shq_pkg;

  // histogram geometry
  localparam int BINS    = 256;
  localparam int BIN_AW  = $clog2(BINS);
  localparam int BIN_W   = 16;
  localparam int CNT_W   = 32;

  // fixed-point log2: 5 integer bits, LOG_FRAC_BITS fraction bits
  localparam int LOG_FRAC_BITS = 16;
  localparam int LOG_INT_W     = 5;
  localparam int LOG_W         = LOG_INT_W + LOG_FRAC_BITS;
  localparam int LOG_CW        = $clog2(LOG_FRAC_BITS);
  localparam int NORM_STEPS    = 5;

  // 3.434 * ln(2) in Q24
  localparam int SCALE_W     = 26;
  localparam int SCALE_SHIFT = 24;
  localparam logic [SCALE_W-1:0] SCALE_Q24 = 26'd39934261;
  localparam int PROD_W      = LOG_W + SCALE_W;
  localparam int Q_W         = PROD_W - LOG_FRAC_BITS - SCALE_SHIFT;
  localparam int SCORE_LIM   = 77;

  localparam logic [BIN_W-1:0] MAX_BIN_RST = 16'd255;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_QUERY     = 2'd1,
    OP_MERGE_BIN = 2'd2,
    OP_MERGE_TOT = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_TOT_ZERO = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [BIN_W-1:0] bin;
    logic [CNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] score;
    status_t           status;
  } out_item_t;

  // write port of the bin memory
  typedef struct packed {
    logic              we;
    logic [BIN_AW-1:0] addr;
    logic [CNT_W-1:0]  data;
  } ram_wr_t;

  // result of a log2 unit
  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] value;
  } log_res_t;

endpackage

// ===== hw/rtl/shq_bin_ram.sv =====
module shq_bin_ram (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [shq_pkg::BIN_AW-1:0]   rd_addr,
  input  shq_pkg::ram_wr_t             wr,
  output logic [shq_pkg::CNT_W-1:0]    rd_data
);
  import shq_pkg::*;

  logic [CNT_W-1:0] bin_mem [BINS];
  logic [BINS-1:0]  vld_r;
  logic [CNT_W-1:0] rd_data_r;
  logic             rd_vld_r;

  // memory write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      bin_mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= bin_mem[rd_addr];
    end
  end

  // written flags, an unwritten bin holds its pseudocount of one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : CNT_W'(1);

  // accesses are interlocked by the controller, never in the same cycle
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr.we))
    else $error("bin memory read and write in the same cycle");

endmodule

// ===== hw/rtl/shq_log2.sv =====
module shq_log2 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [shq_pkg::CNT_W-1:0] x,
  output shq_pkg::log_res_t         res
);
  import shq_pkg::*;

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQR  = 3'b100
  } lstate_t;

  lstate_t                  state_r, state_nxt;
  logic [CNT_W-1:0]         m_r, m_nxt;
  logic [LOG_INT_W-1:0]     e_r, e_nxt;
  logic [LOG_FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [LOG_CW-1:0]        cnt_r, cnt_nxt;
  logic                     done_r, done_nxt;
  logic [2*CNT_W-1:0]       sq;
  logic [CNT_W:0]           sq_t;

  // one squaring of the mantissa per cycle
  assign sq   = m_r * m_r;
  assign sq_t = sq[2*CNT_W-1:CNT_W-1];

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    e_nxt     = e_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          m_nxt     = x;
          e_nxt     = LOG_INT_W'(CNT_W - 1);
          frac_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = L_NORM;
        end
      end
      L_NORM: begin
        // normalise by 16, 8, 4, 2, 1 bit positions
        case (cnt_r)
          LOG_CW'(0): begin
            if (m_r[31:16] == '0) begin
              m_nxt = {m_r[15:0], 16'b0};
              e_nxt = e_r - LOG_INT_W'(16);
            end
          end
          LOG_CW'(1): begin
            if (m_r[31:24] == '0) begin
              m_nxt = {m_r[23:0], 8'b0};
              e_nxt = e_r - LOG_INT_W'(8);
            end
          end
          LOG_CW'(2): begin
            if (m_r[31:28] == '0) begin
              m_nxt = {m_r[27:0], 4'b0};
              e_nxt = e_r - LOG_INT_W'(4);
            end
          end
          LOG_CW'(3): begin
            if (m_r[31:30] == '0) begin
              m_nxt = {m_r[29:0], 2'b0};
              e_nxt = e_r - LOG_INT_W'(2);
            end
          end
          default: begin
            if (!m_r[31]) begin
              m_nxt = {m_r[30:0], 1'b0};
              e_nxt = e_r - LOG_INT_W'(1);
            end
          end
        endcase
        if (cnt_r == LOG_CW'(NORM_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = L_SQR;
        end else begin
          cnt_nxt = cnt_r + LOG_CW'(1);
        end
      end
      L_SQR: begin
        // a square at or above two gives a one bit and halves the mantissa
        m_nxt    = sq_t[CNT_W] ? sq_t[CNT_W:1] : sq_t[CNT_W-1:0];
        frac_nxt = {frac_r[LOG_FRAC_BITS-2:0], sq_t[CNT_W]};
        if (cnt_r == LOG_CW'(LOG_FRAC_BITS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end else begin
          cnt_nxt = cnt_r + LOG_CW'(1);
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign res.done  = done_r;
  assign res.value = {e_r, frac_r};

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == L_IDLE)
    else $error("log2 started while busy");

  a_norm_msb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == L_SQR |-> m_r[CNT_W-1])
    else $error("log2 mantissa not normalised while squaring");

  a_done_after_sqr: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r) == L_SQR)
    else $error("log2 done without a squaring pass");

endmodule

// ===== hw/rtl/score_histogram_quality.sv =====
// channel  direction  handshake            payload
// in_      input      in_valid/in_ready    in_data   (opcode, bin, amount)
// out_     output     out_valid/out_ready  out_data  (score, status)
// cfg_     input      cfg_we               cfg_wdata (max_bin)
//
// an add or merge transaction passes the execute and finish states before out_valid; a
// query runs the bin memory read, then two log2 units side by side running 5
// normalise steps and 16 mantissa squarings on one 32x32 multiplier each, then
// the scaling multiply. one transaction is in work at a time; the next is
// accepted once the previous result sits in the output register. after reset the
// bins read as one through per-bin written flags, with no clearing pass.
module score_histogram_quality (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  shq_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output shq_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [shq_pkg::BIN_W-1:0]     cfg_wdata
);
  import shq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_LOG   = 6'b000100,
    S_MUL   = 6'b001000,
    S_SCALE = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  opcode_t            op_r;
  logic [BIN_W-1:0]   bin_r;
  logic [CNT_W-1:0]   amt_r;
  logic               ok_r;
  logic [CNT_W-1:0]   tot_r, tot_nxt;
  logic [BIN_W-1:0]   max_bin_r;
  logic [LOG_W-1:0]   mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [7:0]         res_score_r, res_score_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               accept;
  logic               bin_ok;
  logic [CNT_W-1:0]   rd_data;
  ram_wr_t            wr;
  logic [CNT_W-1:0]   add_val;
  logic [CNT_W:0]     cnt_sum, tot_sum;
  logic               cnt_sat, tot_sat;
  logic [CNT_W-1:0]   cnt_new, tot_new;
  logic               log_start;
  log_res_t           cnt_res, tot_res;
  logic               cnt_larger;
  logic [Q_W-1:0]     q;
  logic [7:0]         q8;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign bin_ok   = (in_data.bin <= max_bin_r) &&
                    ((BIN_W + 1)'(in_data.bin) < (BIN_W + 1)'(BINS));

  // bin memory, read on acceptance, written back in the execute cycle
  shq_bin_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_data.bin[BIN_AW-1:0]),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // saturating adds on the bin and the total
  assign add_val = (op_r == OP_ADD) ? CNT_W'(1) : amt_r;
  assign cnt_sum = (CNT_W + 1)'(rd_data) + (CNT_W + 1)'(add_val);
  assign tot_sum = (CNT_W + 1)'(tot_r) + (CNT_W + 1)'(add_val);
  assign cnt_sat = cnt_sum[CNT_W];
  assign tot_sat = tot_sum[CNT_W];
  assign cnt_new = cnt_sat ? '1 : cnt_sum[CNT_W-1:0];
  assign tot_new = tot_sat ? '1 : tot_sum[CNT_W-1:0];

  assign wr.we   = (state_r == S_EXEC) && ok_r &&
                   ((op_r == OP_ADD) || (op_r == OP_MERGE_BIN));
  assign wr.addr = bin_r[BIN_AW-1:0];
  assign wr.data = cnt_new;

  assign log_start = (state_r == S_EXEC) && (op_r == OP_QUERY) && ok_r &&
                     (tot_r != '0);

  // log2 of the bin count and of the total
  shq_log2 u_log_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (rd_data),
    .res   (cnt_res)
  );

  shq_log2 u_log_tot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (tot_r),
    .res   (tot_res)
  );

  // scaled magnitude, truncated and clipped
  assign cnt_larger = cnt_res.value > tot_res.value;
  assign q          = prod_r[PROD_W-1 -: Q_W];
  assign q8         = (q > Q_W'(SCORE_LIM)) ? 8'(SCORE_LIM) : 8'(q);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    tot_nxt        = tot_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    res_score_nxt  = res_score_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_score_nxt  = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_FIN;
        case (op_r)
          OP_ADD: begin
            if (!ok_r) begin
              res_status_nxt = ST_RANGE;
            end else begin
              tot_nxt = tot_new;
              if (cnt_sat || tot_sat) begin
                res_status_nxt = ST_SAT;
              end
            end
          end
          OP_QUERY: begin
            if (!ok_r) begin
              res_status_nxt = ST_RANGE;
            end else if (tot_r == '0) begin
              res_status_nxt = ST_TOT_ZERO;
            end else begin
              state_nxt = S_LOG;
            end
          end
          OP_MERGE_BIN: begin
            if (!ok_r) begin
              res_status_nxt = ST_RANGE;
            end else if (cnt_sat) begin
              res_status_nxt = ST_SAT;
            end
          end
          default: begin
            tot_nxt = tot_new;
            if (tot_sat) begin
              res_status_nxt = ST_SAT;
            end
          end
        endcase
      end
      S_LOG: begin
        if (cnt_res.done) begin
          neg_nxt   = cnt_larger;
          mag_nxt   = cnt_larger ? cnt_res.value - tot_res.value
                                 : tot_res.value - cnt_res.value;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(mag_r) * PROD_W'(SCALE_Q24);
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        res_score_nxt = neg_r ? -q8 : q8;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.score  = res_score_r;
          out_data_nxt.status = res_status_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and histogram total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tot_r       <= '0;
      max_bin_r   <= MAX_BIN_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_bin_r <= cfg_wdata;
      end
    end
  end

  // transaction and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.opcode;
      bin_r <= in_data.bin;
      amt_r <= in_data.amount;
      ok_r  <= bin_ok;
    end
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    prod_r       <= prod_nxt;
    res_score_r  <= res_score_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_logs_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_res.done == tot_res.done)
    else $error("log2 units out of step");

  a_write_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |=> state_r == S_FIN)
    else $error("bin write not followed by result");

  a_err_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |-> out_data_r.score == '0)
    else $error("non-zero score with error status");

  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> tot_r >= $past(tot_r))
    else $error("total count decreased");

endmodule
